// ===== hw/rtl/sprc_pkg.sv =====
// ============================================================================
// sprc_pkg - shared types and constants of the status packet receiver
// Operation codes passed from the parser to the executor, status codes,
// queue word layout and the CRC-16 byte update.
// ============================================================================
package sprc_pkg;

    localparam int unsigned MAX_LENGTH_DEFAULT = 256;
    localparam int unsigned QUEUE_DEPTH        = 2;

    localparam logic [7:0]  HDR_BYTE_FF = 8'hFF;
    localparam logic [7:0]  HDR_BYTE_FD = 8'hFD;
    localparam logic [7:0]  HDR_BYTE_00 = 8'h00;
    localparam logic [15:0] CRC_POLY    = 16'h8005;

    // executor operations
    localparam logic [2:0] OP_CRC_START = 3'd0;  // crc <= update(0, FF)
    localparam logic [2:0] OP_CRC       = 3'd1;  // fold byte into crc
    localparam logic [2:0] OP_PARAM     = 3'd2;  // fold byte, emit parameter
    localparam logic [2:0] OP_CRC_LOW   = 3'd3;  // hold received crc low byte
    localparam logic [2:0] OP_CRC_HIGH  = 3'd4;  // compare, emit status
    localparam logic [2:0] OP_BAD_HDR   = 3'd5;  // emit bad header
    localparam logic [2:0] OP_BAD_LEN   = 3'd6;  // emit bad length

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DEV_ERR   = 3'd1;
    localparam logic [2:0] ST_CRC_ERR   = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;

    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] id;
        logic [7:0] err;
    } op_word_t;

    // CRC-16, poly 0x8005, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/status_packet_receiver_crc16_core.sv =====
// ============================================================================
// status_packet_receiver_crc16_core - servo-bus status packet receiver
// Hunts for the FF FF FD 00 header, parses id, length, instruction and
// error byte, emits each parameter byte (none on a device error) and one
// status word per packet after checking the CRC-16 (poly 0x8005, init 0).
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_valid / s_ready  | s_rx_byte
//  m_      | out | m_valid / m_ready  | m_kind, m_param_index, m_param_byte,
//          |     |                    | m_status_code, m_device_error, m_packet_id
//
//  One word per cycle sustained while m_ready stays high: the executor retires
//  one operation a cycle, and a result word passes the queue and the output reg.
//  Reset (aresetn low at a clock edge) returns to hunting, empties the queue
//  and the output register.
//  With m_ready low the result register holds; CRC-only operations still drain,
//  and s_ready drops once a result-carrying operation waits at the queue head
//  with one more operation behind it.
//
module status_packet_receiver_crc16_core #(
    parameter int unsigned MAX_LENGTH = sprc_pkg::MAX_LENGTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_param_index,
    output logic [7:0]  m_param_byte,
    output logic [2:0]  m_status_code,
    output logic [7:0]  m_device_error,
    output logic [7:0]  m_packet_id
);

    sprc_pkg::op_word_t push_word;
    sprc_pkg::op_word_t head;
    logic push, pop, empty, full, take;

    // every byte is taken when the queue has room, even if it is dropped
    assign s_ready = !full;
    assign take    = s_valid && s_ready;

    sprc_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .rx_byte (s_rx_byte),
        .push    (push),
        .word    (push_word)
    );

    sprc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    sprc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_param_index  (m_param_index),
        .m_param_byte   (m_param_byte),
        .m_status_code  (m_status_code),
        .m_device_error (m_device_error),
        .m_packet_id    (m_packet_id)
    );

endmodule

// ===== hw/rtl/sprc_front.sv =====
// ============================================================================
// sprc_front - packet parser
// Tracks the packet phase per received byte and turns each byte into an
// operation word for the executor. Dropped hunt bytes produce no word.
// ============================================================================
module sprc_front #(
    parameter int unsigned MAX_LENGTH = sprc_pkg::MAX_LENGTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,       // byte accepted this cycle
    input  logic [7:0]          rx_byte,
    output logic                push,
    output sprc_pkg::op_word_t  word
);

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_HDR1  = 4'd1;
    localparam logic [3:0] PH_HDR2  = 4'd2;
    localparam logic [3:0] PH_HDR3  = 4'd3;
    localparam logic [3:0] PH_ID    = 4'd4;
    localparam logic [3:0] PH_LENL  = 4'd5;
    localparam logic [3:0] PH_LENH  = 4'd6;
    localparam logic [3:0] PH_INSTR = 4'd7;
    localparam logic [3:0] PH_ERR   = 4'd8;
    localparam logic [3:0] PH_PARAM = 4'd9;
    localparam logic [3:0] PH_CRCL  = 4'd10;
    localparam logic [3:0] PH_CRCH  = 4'd11;

    localparam logic [16:0] MAX_LEN17 = 17'(MAX_LENGTH);

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  err_reg, err_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] length;
    logic        hdr_fail_ff;

    assign length      = {rx_byte, len_lo_reg};
    assign hdr_fail_ff = (rx_byte == sprc_pkg::HDR_BYTE_FF);

    always_comb begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        id_next     = id_reg;
        err_next    = err_reg;
        count_next  = count_reg;
        push        = 1'b1;
        word.op     = sprc_pkg::OP_CRC;
        word.data   = rx_byte;
        word.index  = count_reg;
        word.id     = id_reg;
        word.err    = err_reg;
        case (phase_reg)
            PH_HDR1: begin
                if (rx_byte == sprc_pkg::HDR_BYTE_FF) begin
                    phase_next = PH_HDR2;
                end else begin
                    word.op    = sprc_pkg::OP_BAD_HDR;
                    phase_next = PH_HUNT;
                end
            end
            PH_HDR2: begin
                if (rx_byte == sprc_pkg::HDR_BYTE_FD) begin
                    phase_next = PH_HDR3;
                end else begin
                    word.op    = sprc_pkg::OP_BAD_HDR;
                    phase_next = hdr_fail_ff ? PH_HDR1 : PH_HUNT;
                end
            end
            PH_HDR3: begin
                if (rx_byte == sprc_pkg::HDR_BYTE_00) begin
                    phase_next = PH_ID;
                end else begin
                    word.op    = sprc_pkg::OP_BAD_HDR;
                    phase_next = hdr_fail_ff ? PH_HDR1 : PH_HUNT;
                end
            end
            PH_ID: begin
                id_next    = rx_byte;
                err_next   = 8'h00;
                phase_next = PH_LENL;
            end
            PH_LENL: begin
                len_lo_next = rx_byte;
                phase_next  = PH_LENH;
            end
            PH_LENH: begin
                if (length < 16'd4 || {1'b0, length} > MAX_LEN17) begin
                    word.op    = sprc_pkg::OP_BAD_LEN;
                    phase_next = PH_HUNT;
                end else begin
                    left_next  = length - 16'd4;
                    phase_next = PH_INSTR;
                end
            end
            PH_INSTR: begin
                phase_next = PH_ERR;
            end
            PH_ERR: begin
                err_next   = rx_byte;
                count_next = 8'd0;
                phase_next = (left_reg != 16'd0) ? PH_PARAM : PH_CRCL;
            end
            PH_PARAM: begin
                // device error: parameters only feed the crc
                word.op    = (err_reg != 8'h00) ? sprc_pkg::OP_CRC : sprc_pkg::OP_PARAM;
                count_next = count_reg + 8'd1;
                left_next  = left_reg - 16'd1;
                if (left_reg == 16'd1) begin
                    phase_next = PH_CRCL;
                end
            end
            PH_CRCL: begin
                word.op    = sprc_pkg::OP_CRC_LOW;
                phase_next = PH_CRCH;
            end
            PH_CRCH: begin
                word.op    = sprc_pkg::OP_CRC_HIGH;
                phase_next = PH_HUNT;
            end
            default: begin
                if (rx_byte == sprc_pkg::HDR_BYTE_FF) begin
                    word.op    = sprc_pkg::OP_CRC_START;
                    phase_next = PH_HDR1;
                end else begin
                    push = 1'b0;
                end
            end
        endcase
        if (!take) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else if (take) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            len_lo_reg <= len_lo_next;
            left_reg   <= left_next;
            id_reg     <= id_next;
            err_reg    <= err_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/sprc_fifo.sv =====
// ============================================================================
// sprc_fifo - operation queue
// Short register queue between parser and executor; push and pop may
// happen in the same cycle.
// ============================================================================
module sprc_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sprc_pkg::op_word_t  push_word,
    input  logic                pop,
    output sprc_pkg::op_word_t  head,
    output logic                empty,
    output logic                full
);

    localparam int unsigned DEPTH = sprc_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CFULL = CW'(DEPTH);

    sprc_pkg::op_word_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CFULL);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CFULL)
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push lost in queue");

endmodule

// ===== hw/rtl/sprc_back.sv =====
// ============================================================================
// sprc_back - operation executor
// Runs the CRC, checks it at packet end and builds result words into a
// single output register.
// ============================================================================
module sprc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  sprc_pkg::op_word_t  head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [7:0]          m_param_index,
    output logic [7:0]          m_param_byte,
    output logic [2:0]          m_status_code,
    output logic [7:0]          m_device_error,
    output logic [7:0]          m_packet_id
);

    localparam logic [15:0] CRC_START = sprc_pkg::crc_byte(16'h0000, sprc_pkg::HDR_BYTE_FF);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg;
    logic        valid_reg;
    logic        emits;
    logic        slot_free;
    logic [15:0] crc_upd;
    logic [15:0] got;

    logic       kind_next;
    logic [7:0] idx_next, pb_next, derr_next, pid_next;
    logic [2:0] code_next;

    assign crc_upd   = sprc_pkg::crc_byte(crc_reg, head.data);
    assign got       = {head.data, crc_lo_reg};
    assign emits     = head.op inside {sprc_pkg::OP_PARAM, sprc_pkg::OP_CRC_HIGH,
                                       sprc_pkg::OP_BAD_HDR, sprc_pkg::OP_BAD_LEN};
    assign slot_free = !valid_reg || m_ready;
    assign pop       = !empty && (!emits || slot_free);

    always_comb begin
        crc_next  = crc_reg;
        kind_next = sprc_pkg::KIND_STATUS;
        idx_next  = 8'h00;
        pb_next   = 8'h00;
        code_next = sprc_pkg::ST_OK;
        derr_next = 8'h00;
        pid_next  = 8'h00;
        case (head.op)
            sprc_pkg::OP_CRC_START: crc_next = CRC_START;
            sprc_pkg::OP_CRC:       crc_next = crc_upd;
            sprc_pkg::OP_PARAM: begin
                crc_next  = crc_upd;
                kind_next = sprc_pkg::KIND_PARAM;
                idx_next  = head.index;
                pb_next   = head.data;
                pid_next  = head.id;
            end
            sprc_pkg::OP_CRC_HIGH: begin
                if (head.err != 8'h00) begin
                    code_next = sprc_pkg::ST_DEV_ERR;
                end else if (got != crc_reg) begin
                    code_next = sprc_pkg::ST_CRC_ERR;
                end
                derr_next = head.err;
                pid_next  = head.id;
            end
            sprc_pkg::OP_BAD_HDR: begin
                code_next = sprc_pkg::ST_BAD_HDR;
                if (head.data == sprc_pkg::HDR_BYTE_FF) begin
                    crc_next = CRC_START;  // failing FF opens a new header
                end
            end
            sprc_pkg::OP_BAD_LEN: begin
                code_next = sprc_pkg::ST_BAD_LEN;
                pid_next  = head.id;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop && emits) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            crc_reg <= crc_next;
            if (head.op == sprc_pkg::OP_CRC_LOW) begin
                crc_lo_reg <= head.data;
            end
        end
        if (pop && emits) begin
            m_kind         <= kind_next;
            m_param_index  <= idx_next;
            m_param_byte   <= pb_next;
            m_status_code  <= code_next;
            m_device_error <= derr_next;
            m_packet_id    <= pid_next;
        end
    end

    assign m_valid = valid_reg;

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// tb - self-checking bench for status_packet_receiver_crc16_core
// Streams servo-bus bytes into the receiver through its valid/ready input.
// A byte-level model of the parser runs beside it and predicts every
// parameter and status word. Directed packets cover each header, length,
// device error and CRC case. Random well-formed, broken and noisy traffic
// follows, with random stalls on both channels.
// ============================================================================
module tb;

    localparam int unsigned MAX_LEN   = sprc_pkg::MAX_LENGTH_DEFAULT;
    // bytes counted toward the random budget (directed ones included) and the quiet tail
    localparam int unsigned RAND_WORDS = 580;
    localparam int unsigned TAIL_WORDS = 70;
    // cycles to linger after the last expected word (queue + output reg)
    localparam int unsigned SETTLE    = 8;

    typedef logic [7:0] byte_q_t[$];

    // parser phases of the prediction model
    typedef enum logic [3:0] {
        P_HUNT, P_HDR1, P_HDR2, P_HDR3, P_ID, P_LENL, P_LENH,
        P_INSTR, P_ERR, P_PARAM, P_CRCL, P_CRCH
    } rx_phase_t;

    // one result word as the block presents it
    typedef struct packed {
        logic       kind;
        logic [7:0] index;
        logic [7:0] data;
        logic [2:0] code;
        logic [7:0] err;
        logic [7:0] id;
    } rx_word_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_kind;
    logic [7:0] m_param_index;
    logic [7:0] m_param_byte;
    logic [2:0] m_status_code;
    logic [7:0] m_device_error;
    logic [7:0] m_packet_id;

    // random stalls on both channels only start while this is set
    bit idle_en = 1'b0;

    // predicted words, oldest first
    rx_word_t expected_words[$];

    // bookkeeping
    int unsigned n_fail         = 0;
    int unsigned n_bytes        = 0;
    int unsigned counted_words  = 0;
    int unsigned n_param_words  = 0;
    int unsigned n_code[0:4]    = '{default: 0};
    int unsigned n_packets      = 0;

    // ------------------------------------------------------------------------
    // Prediction state: mirrors the parser registers of the block
    // ------------------------------------------------------------------------
    rx_phase_t   rx_phase  = P_HUNT;
    logic [15:0] crc_acc   = 16'h0000;
    logic [15:0] len_acc   = 16'h0000;
    logic [15:0] left_cnt  = 16'h0000;
    logic [7:0]  id_q      = 8'h00;
    logic [7:0]  err_q     = 8'h00;
    logic [7:0]  crc_lo_q  = 8'h00;
    logic [7:0]  pidx      = 8'h00;

    status_packet_receiver_crc16_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_param_index  (m_param_index),
        .m_param_byte   (m_param_byte),
        .m_status_code  (m_status_code),
        .m_device_error (m_device_error),
        .m_packet_id    (m_packet_id)
    );

    // period 2: rising at odd times, falling at even times
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // CRC-16, poly 0x8005, init 0, bit-serial MSB first
    // ------------------------------------------------------------------------
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ sprc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void push_word(input logic k, input logic [7:0] idx,
                                      input logic [7:0] pb, input logic [2:0] code,
                                      input logic [7:0] derr, input logic [7:0] pid);
        rx_word_t w;
        w.kind  = k;
        w.index = idx;
        w.data  = pb;
        w.code  = code;
        w.err   = derr;
        w.id    = pid;
        expected_words.push_back(w);
    endfunction

    // wrong header byte: report it; an FF opens a fresh header
    function automatic void header_broken(input logic [7:0] b);
        if (b == sprc_pkg::HDR_BYTE_FF) begin
            crc_acc  = crc16_fold(16'h0000, sprc_pkg::HDR_BYTE_FF);
            rx_phase = P_HDR1;
        end else begin
            rx_phase = P_HUNT;
        end
        push_word(sprc_pkg::KIND_STATUS, 8'h00, 8'h00, sprc_pkg::ST_BAD_HDR, 8'h00, 8'h00);
    endfunction

    // advance the parser model by one accepted byte, queue any word it causes
    function automatic void predict_rx(input logic [7:0] b);
        logic [15:0] got;
        logic [2:0]  code;
        case (rx_phase)
            P_HDR1: begin
                if (b != sprc_pkg::HDR_BYTE_FF) begin
                    header_broken(b);
                end else begin
                    crc_acc  = crc16_fold(crc_acc, b);
                    rx_phase = P_HDR2;
                end
            end
            P_HDR2: begin
                if (b != sprc_pkg::HDR_BYTE_FD) begin
                    header_broken(b);
                end else begin
                    crc_acc  = crc16_fold(crc_acc, b);
                    rx_phase = P_HDR3;
                end
            end
            P_HDR3: begin
                if (b != sprc_pkg::HDR_BYTE_00) begin
                    header_broken(b);
                end else begin
                    crc_acc  = crc16_fold(crc_acc, b);
                    rx_phase = P_ID;
                end
            end
            P_ID: begin
                crc_acc  = crc16_fold(crc_acc, b);
                id_q     = b;
                err_q    = 8'h00;
                rx_phase = P_LENL;
            end
            P_LENL: begin
                crc_acc  = crc16_fold(crc_acc, b);
                len_acc  = {8'h00, b};
                rx_phase = P_LENH;
            end
            P_LENH: begin
                crc_acc = crc16_fold(crc_acc, b);
                len_acc = {b, len_acc[7:0]};
                if (len_acc < 16'd4 || 32'(len_acc) > MAX_LEN) begin
                    rx_phase = P_HUNT;
                    push_word(sprc_pkg::KIND_STATUS, 8'h00, 8'h00, sprc_pkg::ST_BAD_LEN,
                              8'h00, id_q);
                end else begin
                    left_cnt = len_acc - 16'd4;
                    rx_phase = P_INSTR;
                end
            end
            P_INSTR: begin
                crc_acc  = crc16_fold(crc_acc, b);
                rx_phase = P_ERR;
            end
            P_ERR: begin
                crc_acc  = crc16_fold(crc_acc, b);
                err_q    = b;
                pidx     = 8'h00;
                rx_phase = (left_cnt != 16'd0) ? P_PARAM : P_CRCL;
            end
            P_PARAM: begin
                crc_acc  = crc16_fold(crc_acc, b);
                left_cnt = left_cnt - 16'd1;
                if (left_cnt == 16'd0) begin
                    rx_phase = P_CRCL;
                end
                // a device error swallows the parameters silently
                if (err_q == 8'h00) begin
                    push_word(sprc_pkg::KIND_PARAM, pidx, b, sprc_pkg::ST_OK, 8'h00, id_q);
                end
                pidx = pidx + 8'd1;
            end
            P_CRCL: begin
                crc_lo_q = b;
                rx_phase = P_CRCH;
            end
            P_CRCH: begin
                got      = {b, crc_lo_q};
                rx_phase = P_HUNT;
                if (err_q != 8'h00) begin
                    code = sprc_pkg::ST_DEV_ERR;
                end else if (got != crc_acc) begin
                    code = sprc_pkg::ST_CRC_ERR;
                end else begin
                    code = sprc_pkg::ST_OK;
                end
                push_word(sprc_pkg::KIND_STATUS, 8'h00, 8'h00, code, err_q, id_q);
            end
            default: begin
                // hunting: only an FF opens a header
                if (b == sprc_pkg::HDR_BYTE_FF) begin
                    crc_acc  = crc16_fold(16'h0000, sprc_pkg::HDR_BYTE_FF);
                    rx_phase = P_HDR1;
                end else begin
                    rx_phase = P_HUNT;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. The input side is
    // handled first so a word can never beat its own prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_rx(s_rx_byte);
                n_bytes++;
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: kind %0d code %0d id 0x%0h",
                           m_kind, m_status_code, m_packet_id);
                    n_fail++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("kind",         want.kind,  m_kind);
                    check_field("param_index",  want.index, m_param_index);
                    check_field("param_byte",   want.data,  m_param_byte);
                    check_field("status_code",  want.code,  m_status_code);
                    check_field("device_error", want.err,   m_device_error);
                    check_field("packet_id",    want.id,    m_packet_id);
                    if (want.kind == sprc_pkg::KIND_PARAM) begin
                        n_param_words++;
                    end else if (want.code <= sprc_pkg::ST_BAD_LEN) begin
                        n_code[want.code]++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure: random bursts with m_ready low
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        int unsigned stall_cnt;
        if (stall_cnt != 0) begin
            stall_cnt = stall_cnt - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(1, 9);
        end
        m_ready <= (stall_cnt == 0);
    end

    // ------------------------------------------------------------------------
    // Sender. Every call starts and ends right after a falling edge; s_valid
    // stays high into the next call so back-to-back words need one write.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_bytes(input byte_q_t seq, input bit counted);
        foreach (seq[i]) begin
            send_byte(seq[i]);
        end
        if (counted) begin
            counted_words += seq.size();
        end
    endtask

    // drop valid and wait for a falling edge
    task automatic sender_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // hold the sender until every predicted word has come out
    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Build and send one packet. A length out of range stops after the length
    // bytes, as the block does. bad_crc corrupts the trailer, hdr_flip
    // spoils one header byte, chop cuts the packet short at a random point.
    task automatic send_packet(input logic [7:0] id, input logic [15:0] len,
                               input logic [7:0] err, input bit bad_crc,
                               input bit hdr_flip, input bit chop);
        byte_q_t     pkt;
        logic [15:0] crc;
        int unsigned pos;
        pkt = {sprc_pkg::HDR_BYTE_FF, sprc_pkg::HDR_BYTE_FF, sprc_pkg::HDR_BYTE_FD,
               sprc_pkg::HDR_BYTE_00, id, len[7:0], len[15:8]};
        if (len >= 16'd4 && 32'(len) <= MAX_LEN) begin
            pkt.push_back(8'($urandom_range(0, 255)));   // instruction
            pkt.push_back(err);
            repeat (len - 4) pkt.push_back(8'($urandom_range(0, 255)));
            crc = 16'h0000;
            foreach (pkt[i]) begin
                crc = crc16_fold(crc, pkt[i]);
            end
            if (bad_crc) begin
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            end
            pkt.push_back(crc[7:0]);
            pkt.push_back(crc[15:8]);
        end
        if (hdr_flip) begin
            pos      = $urandom_range(1, 3);
            pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
        end
        if (chop) begin
            pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
        end
        n_packets++;
        send_bytes(pkt, 1'b1);
    endtask

    function automatic logic [15:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 39);
        if (r == 0) begin
            return 16'(MAX_LEN);
        end else if (r < 6) begin
            return 16'd4;
        end
        return 16'($urandom_range(5, 14));
    endfunction

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // bytes other than FF while hunting give no word
    task automatic test_hunt_noise();
        send_bytes({8'h00, 8'hFD, 8'h7F, 8'hFE}, 1'b0);
    endtask

    // wrong second, third and fourth header bytes, with and without FF
    task automatic test_header_mismatch();
        send_bytes({8'hFF, 8'h00,
                    8'hFF, 8'hFF, 8'h12,
                    8'hFF, 8'hFF, 8'hFD, 8'h55,
                    8'hFF, 8'hFF, 8'hFD, 8'hFF,    // FF restarts the header
                    8'hFF, 8'hFF,                  // FF in place of FD: again
                    8'h00}, 1'b1);                 // then back to hunting
    endtask

    // shortest packet with no parameters, and one with parameters
    task automatic test_good_packets();
        send_packet(8'h00, 16'd4, 8'h00, 1'b0, 1'b0, 1'b0);
        send_packet(8'hFF, 16'd7, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // lengths below 4 and above the maximum
    task automatic test_bad_length();
        send_packet(8'h3C, 16'd3,               8'h00, 1'b0, 1'b0, 1'b0);
        send_packet(8'hC3, 16'(MAX_LEN + 1),    8'h00, 1'b0, 1'b0, 1'b0);
        send_packet(8'h11, 16'd0,               8'h00, 1'b0, 1'b0, 1'b0);
        send_packet(8'hEE, 16'hFFFF,            8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // nonzero error byte: params swallowed, code wins over the CRC check
    task automatic test_device_error();
        send_packet(8'h5A, 16'd6, 8'h80, 1'b0, 1'b0, 1'b0);
        send_packet(8'hA5, 16'd4, 8'hFF, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_crc_mismatch();
        send_packet(8'h01, 16'd5, 8'h00, 1'b1, 1'b0, 1'b0);
    endtask

    // sender holds off until the block has delivered everything
    task automatic test_drain_pause();
        send_packet(8'h42, 16'd6, 8'h00, 1'b0, 1'b0, 1'b0);
        sender_idle();
        wait_drained();
        send_packet(8'h24, 16'd5, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // mostly well-formed packets with random content, the rest broken or noise
    task automatic test_random_traffic();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  err;
        n = 0;
        while (counted_words < RAND_WORDS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                err = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_packet(8'($urandom_range(0, 255)), pick_length(), err,
                            $urandom_range(0, 6) == 0, 1'b0, 1'b0);
            end else if (pick < 80) begin
                send_packet(8'($urandom_range(0, 255)),
                            ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3))
                                : 16'($urandom_range(MAX_LEN + 1, 16'hFFFF)),
                            8'h00, 1'b0, 1'b0, 1'b0);
            end else if (pick < 90) begin
                send_packet(8'($urandom_range(0, 255)), pick_length(), 8'h00, 1'b0,
                            $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            n++;
            if (n % 25 == 0) begin
                sender_idle();
                wait_drained();
            end
        end
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_quiet_tail();
        int unsigned stop_at;
        idle_en = 1'b0;
        stop_at = counted_words + TAIL_WORDS;
        while (counted_words < stop_at) begin
            send_packet(8'($urandom_range(0, 255)), 16'($urandom_range(4, 10)),
                        8'h00, $urandom_range(0, 4) == 0, 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idle_en = 1'b1;
        test_hunt_noise();
        test_header_mismatch();
        test_good_packets();
        test_bad_length();
        test_device_error();
        test_crc_mismatch();
        test_drain_pause();
        test_random_traffic();
        test_quiet_tail();

        sender_idle();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d bytes in %0d packets: %0d parameter words", n_bytes,
                 n_packets, n_param_words);
        $display("status words: ok %0d, device error %0d, crc %0d, header %0d, length %0d",
                 n_code[0], n_code[1], n_code[2], n_code[3], n_code[4]);
        if (n_fail == 0 && expected_words.size() == 0) begin
            $display("status_packet_receiver_crc16_core: match");
        end else begin
            $display("status_packet_receiver_crc16_core: mismatch");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #400000;
        $display("status_packet_receiver_crc16_core: mismatch");
        $finish;
    end

endmodule
